### sv/kv_record_crc_checker_defines.svh
// Assertion macros shared by the record checker RTL.
`ifndef KV_RECORD_CRC_CHECKER_DEFINES_SVH
`define KV_RECORD_CRC_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define KVC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvc assertion failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define KVC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvc assertion failed");
`else
`define KVC_ASSERT_IMP(label, ante, cons)
`define KVC_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/kvc_pkg.sv
// Constants, types and the byte-wise CRC-32 step for the record checker.
package kvc_pkg;

  localparam int MAX_RECORD_BYTES = 4096;
  localparam int HEADER_BYTES     = 12;
  localparam int COUNT_W          = $clog2(MAX_RECORD_BYTES + 2);

  localparam logic [COUNT_W-1:0] COUNT_CAP  = COUNT_W'(MAX_RECORD_BYTES + 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(MAX_RECORD_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_HDR  = COUNT_W'(HEADER_BYTES);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Result field widths
  localparam int STATUS_W  = 2;
  localparam int KEY_LEN_W = 12;
  localparam int VAL_LEN_W = 12;
  localparam int KEY_OFS_W = 4;
  localparam int VAL_OFS_W = 13;
  localparam int RESULT_W  = STATUS_W + KEY_LEN_W + VAL_LEN_W + KEY_OFS_W + VAL_OFS_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LEN_ERR   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CRC_ERR   = 2'd3;

  // Record state after the current byte
  typedef struct packed {
    logic [31:0]        key_length;
    logic [31:0]        value_length;
    logic [31:0]        expected_crc;
    logic [31:0]        crc;
    logic [COUNT_W-1:0] byte_count;
  } rec_state_t;

  // One result item
  typedef struct packed {
    logic [VAL_OFS_W-1:0] value_offset;
    logic [KEY_OFS_W-1:0] key_offset;
    logic [VAL_LEN_W-1:0] value_length;
    logic [KEY_LEN_W-1:0] key_length;
    logic [STATUS_W-1:0]  status;
  } result_t;

  // Reflected CRC-32 update by one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/kvc_in_stage.sv
// Input register for the byte stream.
module kvc_in_stage
  import kvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       take,
  output logic       in_valid,
  output logic [7:0] in_byte,
  output logic       in_last
);

  // Accept when empty or when the held byte moves on this cycle
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold payload until the next transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

endmodule

### sv/kvc_parse.sv
// Header capture, byte counter and running CRC for the current record.
module kvc_parse
  import kvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output rec_state_t rec_next
);

  rec_state_t rec;
  logic [4:0] shift;

  assign shift = {rec.byte_count[1:0], 3'b000};

  // Fold the byte into the header or the CRC, and count it
  always_comb begin
    rec_next = rec;
    if (rec.byte_count < COUNT_W'(4)) begin
      rec_next.key_length = rec.key_length | ({24'd0, data_byte} << shift);
    end else if (rec.byte_count < COUNT_W'(8)) begin
      rec_next.value_length = rec.value_length | ({24'd0, data_byte} << shift);
    end else if (rec.byte_count < COUNT_HDR) begin
      rec_next.expected_crc = rec.expected_crc | ({24'd0, data_byte} << shift);
    end else begin
      rec_next.crc = crc32_byte(rec.crc, data_byte);
    end
    if (rec.byte_count < COUNT_CAP) begin
      rec_next.byte_count = rec.byte_count + COUNT_W'(1);
    end
  end

  // Advance per byte; drop back to the empty record after the last one
  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      rec.key_length   <= '0;
      rec.value_length <= '0;
      rec.expected_crc <= '0;
      rec.crc          <= CRC_INIT;
      rec.byte_count   <= '0;
    end else if (fire) begin
      rec <= rec_next;
    end
  end

endmodule

### sv/kvc_result.sv
// Record checks and the result register.
module kvc_result
  import kvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rec_state_t rec,
  input  logic       m_tready,
  output logic       m_tvalid,
  output result_t    result
);

  logic [33:0] total;
  logic [31:0] val_ofs_sum;
  logic        too_short;
  logic        len_bad;
  logic        crc_bad;
  result_t     result_next;

  // Compare header lengths and CRC against what arrived
  assign total       = 34'(HEADER_BYTES) + {2'b00, rec.key_length} + {2'b00, rec.value_length};
  assign val_ofs_sum = rec.key_length + 32'(HEADER_BYTES);
  assign too_short   = rec.byte_count < COUNT_HDR;
  assign len_bad     = (rec.byte_count > COUNT_MAX) || (total != 34'(rec.byte_count));
  assign crc_bad     = (~rec.crc) != rec.expected_crc;

  always_comb begin
    result_next = '0;
    if (too_short) begin
      result_next.status = STATUS_SHORT;
    end else if (len_bad) begin
      result_next.status = STATUS_LEN_ERR;
    end else if (crc_bad) begin
      result_next.status = STATUS_CRC_ERR;
    end else begin
      result_next.status       = STATUS_OK;
      result_next.key_length   = rec.key_length[KEY_LEN_W-1:0];
      result_next.value_length = rec.value_length[VAL_LEN_W-1:0];
      result_next.key_offset   = KEY_OFS_W'(HEADER_BYTES);
      result_next.value_offset = val_ofs_sum[VAL_OFS_W-1:0];
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

### sv/kv_record_crc_checker.sv
// Key-value record checker: takes one record byte per cycle, on s_tvalid and s_tready,
// with s_tlast on the final byte, and sustains one byte every cycle while the input side
// does not stall. Bytes 0 to 11 are the little-endian key length, value length and
// expected CRC; later bytes go through a byte-wide reflected CRC-32 update, one byte per
// cycle. The result register loads when the last byte moves on from the input register,
// and m_tvalid comes from that register: while the byte sits in the input register, its
// state update and the length and CRC compares run straight into the output register.
// The input side stalls only when a last byte waits while the previous result is not taken.
module kv_record_crc_checker
  import kvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] status, [13:2] key_length,
                                            // [25:14] value_length, [29:26] key_offset,
                                            // [42:30] value_offset, rest zero
);

`include "kv_record_crc_checker_defines.svh"

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       fire;
  logic       load;
  rec_state_t rec_next;
  result_t    result;

  // Middle bytes always advance; a last byte needs room in the output register
  assign fire = in_valid && (!in_last || !m_tvalid || m_tready);
  assign load = fire && in_last;

  kvc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (fire),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last)
  );

  kvc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .last_byte (in_last),
    .rec_next  (rec_next)
  );

  kvc_result u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .rec      (rec_next),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .result   (result)
  );

  // Pack the result, status in the lowest bits
  assign m_tdata = OUT_TDATA_W'({result.value_offset, result.key_offset,
                                 result.value_length, result.key_length, result.status});

  // Checks
  `KVC_ASSERT_IMP(a_ok_offsets, m_tvalid && (result.status == STATUS_OK),
    (result.key_offset == KEY_OFS_W'(HEADER_BYTES)) &&
    (result.value_offset == (VAL_OFS_W'(result.key_length) + VAL_OFS_W'(HEADER_BYTES))))
  `KVC_ASSERT_IMP(a_err_zero, m_tvalid && (result.status != STATUS_OK),
    (result.key_length == '0) && (result.value_length == '0) &&
    (result.key_offset == '0) && (result.value_offset == '0))
  `KVC_ASSERT_IMP(a_stall_cause, !s_tready,
    in_valid && in_last && m_tvalid && !m_tready)
  `KVC_ASSERT_NXT(a_load_shows, load, m_tvalid)

endmodule
